[rtl/bfa_pkg.sv]
`timescale 1ns / 1ps

package bfa_pkg;

  // Fixed field widths of the ports
  localparam int FUNC_W  = 1;
  localparam int ENTRY_W = 4;
  localparam int SIZE_W  = 16;
  localparam int CFG_W   = 5;
  localparam int CHOSEN_W = 4;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,    // waiting for a request
    ST_SCAN,    // issuing table reads, one entry a cycle
    ST_LAST,    // comparing the last entry read
    ST_FINISH   // write back the winner and post the result
  } state_t;

endpackage

[rtl/best_fit_block_allocator_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_func, in_entry_index, in_size_value
// out_      output     out_valid / out_ready  out_found, out_chosen_block
// cfg_      input      cfg_we (no wait)       cfg_data (blocks_in_use)
//
// Load: writes one table entry, if its index lies within the table. Allocate, with
// N = min(blocks_in_use, MAX_BLOCKS): N table reads feed the shared compare unit, the
// LAST state compares the last entry and the FINISH state writes back the winner, if
// any, and posts the result; a new request can be taken as soon as out_valid rises.
// Reset clears the sequencer, the result slot and blocks_in_use, not the table.
// A waiting result holds an allocate in its last cycle, in_ready low, until out_ready.

module best_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfa_pkg::FUNC_W-1:0]   in_func,
  input  logic [bfa_pkg::ENTRY_W-1:0]  in_entry_index,
  input  logic [bfa_pkg::SIZE_W-1:0]   in_size_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [bfa_pkg::CHOSEN_W-1:0] out_chosen_block,
  // configuration
  input  logic                         cfg_we,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_data
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  bfa_pkg::state_t state_r, state_nxt;

  logic [bfa_pkg::CFG_W-1:0] cfg_r;
  logic [CNT_W-1:0]          limit;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic [SIZE_BITS-1:0]      req_r, req_nxt;
  logic                      have_r, have_nxt;
  logic [IDX_W-1:0]          best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0]      best_val_r, best_val_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      found_r, found_nxt;
  logic [bfa_pkg::CHOSEN_W-1:0] chosen_r, chosen_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 is_load;
  logic                 load_ok;
  logic                 last_issue;
  logic [31:0]          entry_ext;
  logic [31:0]          size_ext;
  logic [31:0]          best_ext;
  logic [SIZE_BITS-1:0] in_size;

  // table ports
  logic                 tbl_we;
  logic [IDX_W-1:0]     tbl_waddr;
  logic [SIZE_BITS-1:0] tbl_wdata;
  logic [SIZE_BITS-1:0] tbl_rdata;

  // shared compare unit
  logic fits, better, take;

  assign in_ready  = (state_r == bfa_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign is_load   = (in_func == bfa_pkg::FUNC_LOAD);
  assign entry_ext = 32'(in_entry_index);
  assign size_ext  = 32'(in_size_value);
  assign in_size   = size_ext[SIZE_BITS-1:0];
  assign load_ok   = (entry_ext < 32'(MAX_BLOCKS));
  assign best_ext  = 32'(best_idx_r);

  // entries beyond the table do not take part
  assign limit = (32'(cfg_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(cfg_r);
  assign last_issue = (cnt_r == limit - CNT_W'(1));

  assign fits   = (tbl_rdata >= req_r);
  assign better = !have_r || (best_val_r > tbl_rdata);  // strict: lowest index wins ties
  assign take   = rd_vld_r && fits && better;

  bfa_table #(
    .DEPTH  (MAX_BLOCKS),
    .IDX_W  (IDX_W),
    .DATA_W (SIZE_BITS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (tbl_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfa_pkg::ST_IDLE: begin
        if (in_acc && !is_load) begin
          state_nxt = (limit == '0) ? bfa_pkg::ST_FINISH : bfa_pkg::ST_SCAN;
        end
      end
      bfa_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_nxt = bfa_pkg::ST_LAST;
        end
      end
      bfa_pkg::ST_LAST: begin
        state_nxt = bfa_pkg::ST_FINISH;
      end
      bfa_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = bfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfa_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = cnt_r[IDX_W-1:0];
    req_nxt       = req_r;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    found_nxt     = found_r;
    chosen_nxt    = chosen_r;
    tbl_we        = 1'b0;
    tbl_waddr     = entry_ext[IDX_W-1:0];
    tbl_wdata     = in_size;

    // compare the entry read last cycle
    if (take) begin
      have_nxt     = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_val_nxt = tbl_rdata;
    end

    unique case (state_r)
      bfa_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_load) begin
            tbl_we = load_ok;
          end else begin
            req_nxt  = in_size;
            have_nxt = 1'b0;
            cnt_nxt  = '0;
          end
        end
      end
      bfa_pkg::ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
      end
      bfa_pkg::ST_LAST: begin
      end
      bfa_pkg::ST_FINISH: begin
        if (out_free) begin
          tbl_we        = have_r;
          tbl_waddr     = best_idx_r;
          tbl_wdata     = best_val_r - req_r;
          out_valid_nxt = 1'b1;
          found_nxt     = have_r;
          chosen_nxt    = have_r ? best_ext[bfa_pkg::CHOSEN_W-1:0] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::ST_IDLE;
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      have_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      have_r      <= have_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    req_r      <= req_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    found_r    <= found_nxt;
    chosen_r   <= chosen_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_chosen_block = chosen_r;

endmodule

[rtl/bfa_table.sv]
`timescale 1ns / 1ps

module bfa_table #(
  parameter int DEPTH  = 16,
  parameter int IDX_W  = 4,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Single write port, registered read; contents undefined until loaded.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
